FILE: design/bfnr_pkg.sv
package bfnr_pkg;

    localparam logic [3:0] OP_TEST      = 4'd0;
    localparam logic [3:0] OP_SET       = 4'd1;
    localparam logic [3:0] OP_CLEAR     = 4'd2;
    localparam logic [3:0] OP_SET_BELOW = 4'd3;
    localparam logic [3:0] OP_CLEAR_ALL = 4'd4;
    localparam logic [3:0] OP_COUNT     = 4'd5;
    localparam logic [3:0] OP_ANY       = 4'd6;
    localparam logic [3:0] OP_NEXT      = 4'd7;
    localparam logic [3:0] OP_RANK      = 4'd8;

    localparam logic [5:0] ACTIVE_BYTES_RESET = 6'd32;
    localparam logic [7:0] BYTE_ALL_ONES      = 8'hFF;

    typedef struct packed {
        logic [3:0] pop;
        logic [2:0] first;
        logic       nonzero;
    } byte_res_t;

    function automatic logic [7:0] low_mask(input logic [2:0] bit_pos);
        return (8'h01 << bit_pos) - 8'h01;
    endfunction

    function automatic logic [7:0] high_mask(input logic [2:0] bit_pos);
        return BYTE_ALL_ONES << bit_pos;
    endfunction

endpackage

FILE: design/bfnr_ram.sv
module bfnr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bfnr_byte_unit.sv
module bfnr_byte_unit
    import bfnr_pkg::*;
(
    input  logic [7:0] data,
    input  logic [7:0] mask,
    output byte_res_t  res
);

    logic [7:0] masked;
    logic [3:0] pop;
    logic [2:0] first;

    assign masked = data & mask;

    always_comb
    begin
        pop = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            pop = pop + {3'd0, masked[i]};
        end
    end

    // Priority search from the top down leaves the lowest set bit.
    always_comb
    begin
        first = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (masked[i])
            begin
                first = 3'(i);
            end
        end
    end

    assign res.pop     = pop;
    assign res.first   = first;
    assign res.nonzero = |masked;

endmodule

FILE: design/bitmap_find_next_and_rank_core.sv
// Commands with an index outside the active length or an unknown opcode skip the store;
// test, set and clear pass once through read and execute; scanning commands pass through
// read and execute once per byte visited (count and any visit every active byte, set below
// and rank bytes 0 through the indexed byte, next the indexed byte through the first set
// bit or the last active byte). Clear all sweeps the store one byte per cycle. One item
// is in work at a time. Reset runs the same clearing pass with in_ready low.
module bitmap_find_next_and_rank_core
    import bfnr_pkg::*;
#(
    parameter int MAX_BYTES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] opcode,
    input  logic [7:0] bit_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       flag,
    output logic [8:0] value,
    output logic       error
);

    localparam int AW   = MAX_BYTES > 1 ? $clog2(MAX_BYTES) : 1;
    localparam int CW   = $clog2(MAX_BYTES + 1);
    localparam int CMPW = CW > 6 ? CW : 6;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic        reply_reg, reply_next;
    logic [5:0]  active_bytes_reg;
    logic        out_valid_reg, out_valid_next;

    logic [3:0]  op_reg, op_next;
    logic [7:0]  idx_reg, idx_next;
    logic        res_flag_reg, res_flag_next;
    logic [8:0]  res_val_reg, res_val_next;
    logic        res_err_reg, res_err_next;
    logic        out_flag_reg;
    logic [8:0]  out_value_reg;
    logic        out_error_reg;

    logic            ram_we;
    logic [7:0]      ram_wdata;
    logic            ram_re;
    logic [7:0]      ram_rdata;
    logic [7:0]      unit_mask;
    byte_res_t       unit_res;

    logic [CMPW-1:0] len;
    logic [CMPW-1:0] act_ext;
    logic [CMPW-1:0] ptr_ext;
    logic [CMPW-1:0] in_pos;
    logic [CMPW-1:0] cur_pos;
    logic            in_range;
    logic            at_last;
    logic            at_pos;
    logic [2:0]      cur_bit;
    logic            out_free;

    assign act_ext  = CMPW'(active_bytes_reg);
    assign len      = act_ext > CMPW'(MAX_BYTES) ? CMPW'(MAX_BYTES) : act_ext;
    assign ptr_ext  = CMPW'(ptr_reg);
    assign in_pos   = CMPW'(bit_index[7:3]);
    assign cur_pos  = CMPW'(idx_reg[7:3]);
    assign cur_bit  = idx_reg[2:0];
    assign in_range = in_pos < len;
    assign at_last  = ptr_ext == len - CMPW'(1);
    assign at_pos   = ptr_ext == cur_pos;
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        unit_mask = BYTE_ALL_ONES;
        case (op_reg)
            OP_NEXT: unit_mask = at_pos ? high_mask(cur_bit) : BYTE_ALL_ONES;
            OP_RANK: unit_mask = at_pos ? low_mask(cur_bit) : BYTE_ALL_ONES;
            default: unit_mask = BYTE_ALL_ONES;
        endcase
    end

    bfnr_byte_unit u_unit (
        .data (ram_rdata),
        .mask (unit_mask),
        .res  (unit_res)
    );

    bfnr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        reply_next     = reply_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        res_flag_next  = res_flag_reg;
        res_val_next   = res_val_reg;
        res_err_next   = res_err_reg;
        ram_we         = 1'b0;
        ram_wdata      = 8'd0;
        ram_re         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = opcode;
                    idx_next      = bit_index;
                    res_flag_next = 1'b0;
                    res_val_next  = 9'd0;
                    res_err_next  = 1'b0;
                    ptr_next      = '0;
                    state_next    = S_RESP;
                    case (opcode)
                        OP_TEST, OP_NEXT:
                        begin
                            if (in_range)
                            begin
                                ptr_next   = CW'(in_pos);
                                state_next = S_READ;
                            end
                        end
                        OP_SET, OP_CLEAR:
                        begin
                            if (in_range)
                            begin
                                ptr_next   = CW'(in_pos);
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_err_next = 1'b1;
                            end
                        end
                        OP_SET_BELOW, OP_RANK:
                        begin
                            if (in_range)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_err_next = 1'b1;
                            end
                        end
                        OP_CLEAR_ALL:
                        begin
                            reply_next = 1'b1;
                            state_next = S_CLEAR;
                        end
                        OP_COUNT, OP_ANY:
                        begin
                            if (len != '0)
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_err_next = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (ptr_reg == CW'(MAX_BYTES - 1))
                begin
                    ptr_next   = '0;
                    state_next = reply_reg ? S_RESP : S_IDLE;
                    reply_next = 1'b0;
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                case (op_reg)
                    OP_TEST:
                    begin
                        res_flag_next = ram_rdata[cur_bit];
                    end
                    OP_SET:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | (8'h01 << cur_bit);
                    end
                    OP_CLEAR:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~(8'h01 << cur_bit);
                    end
                    OP_SET_BELOW:
                    begin
                        ram_we = 1'b1;
                        if (at_pos)
                        begin
                            ram_wdata = ram_rdata | low_mask(cur_bit);
                        end
                        else
                        begin
                            ram_wdata  = BYTE_ALL_ONES;
                            ptr_next   = ptr_reg + CW'(1);
                            state_next = S_READ;
                        end
                    end
                    OP_COUNT, OP_ANY:
                    begin
                        res_val_next = op_reg == OP_COUNT ?
                                       res_val_reg + 9'(unit_res.pop) : 9'd0;
                        res_flag_next = op_reg == OP_ANY ?
                                        (res_flag_reg | unit_res.nonzero) : 1'b0;
                        if (!at_last)
                        begin
                            ptr_next   = ptr_reg + CW'(1);
                            state_next = S_READ;
                        end
                    end
                    OP_NEXT:
                    begin
                        if (unit_res.nonzero)
                        begin
                            res_flag_next = 1'b1;
                            res_val_next  = {ptr_ext[5:0], 3'b000} + 9'(unit_res.first);
                        end
                        else if (!at_last)
                        begin
                            ptr_next   = ptr_reg + CW'(1);
                            state_next = S_READ;
                        end
                    end
                    OP_RANK:
                    begin
                        if (at_pos)
                        begin
                            if (ram_rdata[cur_bit])
                            begin
                                res_val_next = res_val_reg + 9'(unit_res.pop);
                            end
                            else
                            begin
                                res_err_next = 1'b1;
                                res_val_next = 9'd0;
                            end
                        end
                        else
                        begin
                            res_val_next = res_val_reg + 9'(unit_res.pop);
                            ptr_next     = ptr_reg + CW'(1);
                            state_next   = S_READ;
                        end
                    end
                    default:
                    begin
                        res_err_next = 1'b1;
                    end
                endcase
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            ptr_reg          <= '0;
            reply_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
            active_bytes_reg <= ACTIVE_BYTES_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            reply_reg     <= reply_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                active_bytes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        res_flag_reg <= res_flag_next;
        res_val_reg  <= res_val_next;
        res_err_reg  <= res_err_next;
        if (state_reg == S_RESP && out_free)
        begin
            out_flag_reg  <= res_flag_reg;
            out_value_reg <= res_val_reg;
            out_error_reg <= res_err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign flag      = out_flag_reg;
    assign value     = out_value_reg;
    assign error     = out_error_reg;

endmodule

FILE: design/bfnr_checker.sv
module bfnr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       flag,
    input logic [8:0] value,
    input logic       error
);

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(flag)
                                    && $stable(error))
        else $error("stalled result changed");

    // Every error case reports a cleared flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> !flag)
        else $error("flag set on an error result");

    // Every error case reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> value == 9'd0)
        else $error("nonzero value on an error result");

    // An accepted item occupies the block for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held after accepting an item");

endmodule

bind bitmap_find_next_and_rank_core bfnr_checker u_bfnr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flag      (flag),
    .value     (value),
    .error     (error)
);

FILE: verif/bitmap_find_next_and_rank_core_test.sv
module bitmap_find_next_and_rank_core_test
    import bfnr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = 32;
    localparam int NUM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_AFTER_RESULTS = 60;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_PRINTED = 100;
    localparam logic [3:0] OP_UNUSED_LO = OP_RANK + 4'd1;
    localparam logic [3:0] OP_UNUSED_HI = 4'hF;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] idx;
    } command_t;

    typedef struct packed {
        logic       flag;
        logic [8:0] value;
        logic       error;
    } bitmap_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [3:0] opcode = '0;
    logic [7:0] bit_index = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       flag;
    logic [8:0] value;
    logic       error;

    command_t       pending_commands[$];
    bitmap_result_t expected_results[$];

    logic [7:0] shadow_map [STORE_BYTES];
    logic [5:0] shadow_active = ACTIVE_BYTES_RESET;

    int  sender_idle_pct = 0;
    int  stall_pct = 0;
    bit  long_hold_req = 1'b0;
    bit  long_hold_done = 1'b0;
    int  hold_left = 0;
    int  checked_count = 0;
    int  mismatch_count = 0;
    int  quiet_cycles = 0;

    bitmap_find_next_and_rank_core #(
        .MAX_BYTES(STORE_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .bit_index(bit_index),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .flag(flag),
        .value(value),
        .error(error)
    );

    always #5 clk = ~clk;

    // Applies one command to the shadow bitmap and returns the answer the block owes.
    function automatic bitmap_result_t apply_command(logic [3:0] op, logic [7:0] idx);
        bitmap_result_t res;
        int len;
        int byte_pos;
        int bit_pos;
        int p;
        bit in_range;
        res = '0;
        len = (shadow_active > STORE_BYTES) ? STORE_BYTES : int'(shadow_active);
        byte_pos = idx >> 3;
        bit_pos = idx[2:0];
        in_range = byte_pos < len;
        case (op)
            OP_TEST:
                if (in_range)
                    res.flag = shadow_map[byte_pos][bit_pos];
            OP_SET:
                if (in_range)
                    shadow_map[byte_pos][bit_pos] = 1'b1;
                else
                    res.error = 1'b1;
            OP_CLEAR:
                if (in_range)
                    shadow_map[byte_pos][bit_pos] = 1'b0;
                else
                    res.error = 1'b1;
            OP_SET_BELOW:
                if (in_range)
                begin
                    for (p = 0; p < idx; p++)
                        shadow_map[p >> 3][p % 8] = 1'b1;
                end
                else
                    res.error = 1'b1;
            OP_CLEAR_ALL:
                for (p = 0; p < STORE_BYTES; p++)
                    shadow_map[p] = '0;
            OP_COUNT:
                for (p = 0; p < len * 8; p++)
                    res.value += shadow_map[p >> 3][p % 8];
            OP_ANY:
                for (p = 0; p < len; p++)
                    if (shadow_map[p] != '0)
                        res.flag = 1'b1;
            OP_NEXT:
                if (in_range)
                begin
                    for (p = idx; p < len * 8 && !res.flag; p++)
                    begin
                        if (shadow_map[p >> 3][p % 8])
                        begin
                            res.flag = 1'b1;
                            res.value = 9'(p);
                        end
                    end
                end
            OP_RANK:
                if (in_range && shadow_map[byte_pos][bit_pos])
                begin
                    for (p = 0; p < idx; p++)
                        res.value += shadow_map[p >> 3][p % 8];
                end
                else
                    res.error = 1'b1;
            default:
                res.error = 1'b1;
        endcase
        return res;
    endfunction

    // Most indexes land inside the active bitmap so that the state gets exercised.
    function automatic command_t random_command(int len);
        command_t c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            c.op = OP_TEST;
        else if (pick < 30)
            c.op = OP_SET;
        else if (pick < 40)
            c.op = OP_CLEAR;
        else if (pick < 45)
            c.op = OP_SET_BELOW;
        else if (pick < 47)
            c.op = OP_CLEAR_ALL;
        else if (pick < 55)
            c.op = OP_COUNT;
        else if (pick < 61)
            c.op = OP_ANY;
        else if (pick < 79)
            c.op = OP_NEXT;
        else if (pick < 97)
            c.op = OP_RANK;
        else
            c.op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        if (len > 0 && $urandom_range(99) < 75)
            c.idx = 8'($urandom_range(len * 8 - 1));
        else
            c.idx = 8'($urandom_range(255));
        return c;
    endfunction

    function automatic logic [5:0] phase_active_bytes(int phase);
        case (phase)
            1: return 6'd1;
            2: return 6'd63;
            3: return 6'd0;
            4: return 6'd5;
            5: return 6'd17;
            6: return 6'd33;
            7: return 6'd32;
            8: return 6'd12;
            default: return ACTIVE_BYTES_RESET;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_command(logic [3:0] op, logic [7:0] idx);
        command_t c;
        c.op = op;
        c.idx = idx;
        pending_commands.push_back(c);
    endfunction

    // Command driver: the expectation is computed at the edge where the item is taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_command(opcode, bit_index));
            if (!in_valid || in_ready)
            begin
                if (pending_commands.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    opcode <= pending_commands[0].op;
                    bit_index <= pending_commands[0].idx;
                    void'(pending_commands.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        bitmap_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                checked_count <= checked_count + 1;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", value, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (flag !== want.flag)
                        report_mismatch("flag", flag, want.flag);
                    if (value !== want.value)
                        report_mismatch("value", value, want.value);
                    if (error !== want.error)
                        report_mismatch("error", error, want.error);
                end
            end
        end
    end

    // Ready generator with one long hold.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (long_hold_req && !long_hold_done && checked_count >= HOLD_AFTER_RESULTS)
            begin
                // Keep the output blocked long enough for the input side to back up.
                out_ready <= 1'b0;
                hold_left <= LONG_HOLD_CYCLES;
                long_hold_done <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int phase;
        int len;
        int n;
        for (n = 0; n < STORE_BYTES; n++)
            shadow_map[n] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            @(negedge clk);
            case (phase % 4)
                0: begin sender_idle_pct = 0; stall_pct = 0; end
                1: begin sender_idle_pct = 70; stall_pct = 0; end
                2: begin sender_idle_pct = 0; stall_pct = 70; end
                default: begin sender_idle_pct = 27; stall_pct = 27; end
            endcase

            if (phase != 0)
            begin
                @(posedge clk);
                cfg_valid <= 1'b1;
                cfg_data <= phase_active_bytes(phase);
                do
                    @(posedge clk);
                while (!cfg_ready);
                shadow_active = cfg_data;
                cfg_valid <= 1'b0;
                @(negedge clk);
            end

            len = (shadow_active > STORE_BYTES) ? STORE_BYTES : int'(shadow_active);
            if (phase == 0)
            begin
                // Empty map, sparse map with both ends set, set below, clear all, bad opcodes.
                push_command(OP_TEST, 8'd0);
                push_command(OP_ANY, 8'd0);
                push_command(OP_COUNT, 8'd0);
                push_command(OP_NEXT, 8'd0);
                push_command(OP_RANK, 8'd0);
                push_command(OP_SET, 8'd0);
                push_command(OP_SET, 8'd255);
                push_command(OP_SET, 8'd77);
                push_command(OP_TEST, 8'd255);
                push_command(OP_COUNT, 8'd0);
                push_command(OP_NEXT, 8'd1);
                push_command(OP_NEXT, 8'd78);
                push_command(OP_RANK, 8'd255);
                push_command(OP_RANK, 8'd77);
                push_command(OP_CLEAR, 8'd77);
                push_command(OP_RANK, 8'd77);
                push_command(OP_SET_BELOW, 8'd0);
                push_command(OP_SET_BELOW, 8'd200);
                push_command(OP_COUNT, 8'd0);
                push_command(OP_CLEAR, 8'd255);
                push_command(OP_CLEAR_ALL, 8'd0);
                push_command(OP_ANY, 8'd0);
                push_command(OP_UNUSED_LO, 8'd13);
                push_command(OP_UNUSED_HI, 8'd0);
                long_hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE)
                pending_commands.push_back(random_command(len));

            do
                @(negedge clk);
            while (pending_commands.size() != 0 || in_valid || expected_results.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: bitmap_find_next_and_rank_core.f
design/bfnr_pkg.sv
design/bfnr_ram.sv
design/bfnr_byte_unit.sv
design/bitmap_find_next_and_rank_core.sv
design/bfnr_checker.sv
verif/bitmap_find_next_and_rank_core_test.sv
